### hdl/fde_pkg.sv
`default_nettype none
package fde_pkg;

	// Store size used when the top level is not overridden
	localparam int STORE_DEPTH_DEF = 131072;

	// Field and register widths
	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 18;
	localparam int FBK_W    = 15;
	localparam int MIX_W    = 16;

	// Register reset values and gain limits (gains in Q1.15)
	localparam logic [DELAY_W-1:0] DELAY_RESET = 18'd11520;
	localparam logic [FBK_W-1:0]   FBK_RESET   = 15'd9175;
	localparam logic [MIX_W-1:0]   MIX_RESET   = 16'd9830;
	localparam logic [FBK_W-1:0]   FBK_MAX     = 15'd31129;
	localparam logic [MIX_W-1:0]   MIX_MAX     = 16'd32768;

	// Q1.15 rounding
	localparam int Q15_SHIFT = 15;

	// Register index on the config port (word address)
	typedef enum logic [1:0] {
		REG_DELAY = 2'd0,
		REG_FBK   = 2'd1,
		REG_MIX   = 2'd2
	} reg_idx_t;

	// Gain settings handed to the back end
	typedef struct packed {
		logic [FBK_W-1:0] fbk;
		logic [MIX_W-1:0] mix;
	} gain_t;

endpackage
`default_nettype wire

### hdl/fde_queue.sv
`default_nettype none
module fde_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              valid,
	output logic [W-1:0]      pop_data
);
	import fde_pkg::*;

	logic [W-1:0] ent_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign pop_data = ent_q[rptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= push_data;
	end

endmodule
`default_nettype wire

### hdl/fde_front.sv
`default_nettype none
module fde_front #(
	parameter int DEPTH = 131072,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int QW = 16 + 2 * AW + 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,   // [15:0] sample_in
	input  wire logic [fde_pkg::DELAY_W-1:0] delay,
	input  wire logic                        q_full,
	output logic                             q_push,
	output logic [QW-1:0]                    q_data
);
	import fde_pkg::*;

	// Work item for the back end
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic [AW-1:0]              rd;
		logic [AW-1:0]              wp;
		logic                       rd_valid;
	} qent_t;

	localparam int SW = (AW + 2 > DELAY_W + 1) ? AW + 2 : DELAY_W + 1;
	localparam logic [SW-1:0] DEPTH_X = SW'(DEPTH);
	localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic [SW-1:0] d_ext;
	logic [SW-1:0] d_clamp;
	logic [SW-1:0] rd_sum;
	logic [SW-1:0] rd_wrap;
	qent_t         ent;

	assign s_tready = ~q_full;
	assign q_push   = s_tvalid & ~q_full;
	assign q_data   = ent;

	// Read point: delay clamped to [1, DEPTH], then wp - delay mod DEPTH
	always_comb begin
		d_ext = SW'(delay);
		if (d_ext == '0) begin
			d_clamp = SW'(1);
		end else if (d_ext > DEPTH_X) begin
			d_clamp = DEPTH_X;
		end else begin
			d_clamp = d_ext;
		end
		rd_sum  = SW'(wp_q) + DEPTH_X - d_clamp;
		rd_wrap = (rd_sum >= DEPTH_X) ? rd_sum - DEPTH_X : rd_sum;

		ent.x        = signed'(s_tdata);
		ent.rd       = rd_wrap[AW-1:0];
		ent.wp       = wp_q;
		// an entry holds data once the write pointer has passed it
		ent.rd_valid = wrapped_q | (rd_wrap[AW-1:0] < wp_q);
	end

	// Write pointer and fill tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (q_push) begin
			if (wp_q == WP_LAST) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hdl/fde_back.sv
`default_nettype none
module fde_back #(
	parameter int DEPTH = 131072,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int QW = 16 + 2 * AW + 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire logic [QW-1:0]  q_data,
	output logic                q_pop,
	input  wire fde_pkg::gain_t gain,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [15:0]         m_tdata    // [15:0] sample_out
);
	import fde_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic [AW-1:0]              rd;
		logic [AW-1:0]              wp;
		logic                       rd_valid;
	} qent_t;

	localparam int OD  = 4;
	localparam int OAW = 2;
	localparam int CW  = 3;

	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		if (v > 34'sd32767) return 16'sh7fff;
		if (v < -34'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	qent_t ent;
	assign ent = q_data;

	// Echo store
	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	// Issue control
	logic          issue;
	logic          gap_q;
	logic [CW-1:0] cnt_q;
	logic          pop_out;

	// Stage 1: read in flight
	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [AW-1:0]              wa_s1;
	logic                       rv_s1;
	logic                       byp_s1;
	logic [SAMPLE_W-1:0]        byp_data_s1;

	// Stage 2: products
	logic                       v_s2;
	logic signed [SAMPLE_W-1:0] x_s2;
	logic [AW-1:0]              wa_s2;
	logic signed [31:0]         pfb_s2;
	logic signed [32:0]         pdry_s2;
	logic signed [32:0]         pwet_s2;

	// Output buffer
	logic [SAMPLE_W-1:0] obuf_q [OD];
	logic [OAW-1:0]      owp_q;
	logic [OAW-1:0]      orp_q;
	logic [CW-1:0]       ocnt_q;

	logic [FBK_W-1:0]         fbk_c;
	logic [MIX_W-1:0]         mix_c;
	logic signed [15:0]       fbk_g;
	logic signed [16:0]       wet_g;
	logic signed [16:0]       dry_g;
	logic signed [15:0]       delayed;
	logic signed [31:0]       fb_sum;
	logic signed [31:0]       fb_sh;
	logic signed [17:0]       wsum;
	logic signed [33:0]       acc_sum;
	logic signed [33:0]       acc_sh;
	logic                     wr_en;
	logic [SAMPLE_W-1:0]      wr_data;
	logic [SAMPLE_W-1:0]      out_data;

	// No item right after another (gap_q), and only with room reserved in the output buffer
	assign issue   = q_valid & ~gap_q & (cnt_q < CW'(OD));
	assign q_pop   = issue;
	assign pop_out = m_tvalid & m_tready;

	// Gain clamping
	always_comb begin
		fbk_c = (gain.fbk > FBK_MAX) ? FBK_MAX : gain.fbk;
		mix_c = (gain.mix > MIX_MAX) ? MIX_MAX : gain.mix;
		fbk_g = signed'({1'b0, fbk_c});
		wet_g = signed'({1'b0, mix_c});
		dry_g = signed'(17'd32768 - {1'b0, mix_c});
	end

	// Delayed sample: forwarded write, stored entry, or zero if never written
	always_comb begin
		if (byp_s1) begin
			delayed = signed'(byp_data_s1);
		end else if (rv_s1) begin
			delayed = signed'(rdata_q);
		end else begin
			delayed = '0;
		end
	end

	// Rounding and saturation of feedback write and output mix
	always_comb begin
		fb_sum   = pfb_s2 + 32'sd16384;
		fb_sh    = fb_sum >>> Q15_SHIFT;
		wsum     = {{2{x_s2[15]}}, x_s2} + fb_sh[17:0];
		acc_sum  = {pdry_s2[32], pdry_s2} + {pwet_s2[32], pwet_s2} + 34'sd16384;
		acc_sh   = acc_sum >>> Q15_SHIFT;
		wr_en    = v_s2;
		wr_data  = sat16({{16{wsum[17]}}, wsum});
		out_data = sat16(acc_sh);
	end

	// Store: read-first, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) mem[wa_s2] <= wr_data;
		if (issue) rdata_q <= mem[ent.rd];
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= 1'b0;
			cnt_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			gap_q  <= issue;
			cnt_q  <= cnt_q + CW'(issue) - CW'(pop_out);
			v_s1   <= issue;
			v_s2   <= v_s1;
			if (v_s2) owp_q <= owp_q + OAW'(1);
			if (pop_out) orp_q <= orp_q + OAW'(1);
			ocnt_q <= ocnt_q + CW'(v_s2) - CW'(pop_out);
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1        <= ent.x;
			wa_s1       <= ent.wp;
			rv_s1       <= ent.rd_valid;
			// write landing on the entry being read this cycle
			byp_s1      <= wr_en & (wa_s2 == ent.rd);
			byp_data_s1 <= wr_data;
		end
		if (v_s1) begin
			x_s2    <= x_s1;
			wa_s2   <= wa_s1;
			pfb_s2  <= delayed * fbk_g;
			pdry_s2 <= x_s1 * dry_g;
			pwet_s2 <= delayed * wet_g;
		end
		if (v_s2) obuf_q[owp_q] <= out_data;
	end

	assign m_tvalid = (ocnt_q != '0);
	assign m_tdata  = obuf_q[orp_q];

endmodule
`default_nettype wire

### hdl/feedback_delay_echo.sv
`default_nettype none
// Feedback delay echo on a stream of signed Q1.15 samples. Each sample taken
// on the s_ side reads the store entry delay_samples behind the write point
// (0 acts as 1, values above STORE_DEPTH act as STORE_DEPTH), writes back the
// input plus the delayed sample times feedback_gain (limited to 0.95), and
// gives one sample on the m_ side: input*(1-wet_mix) + delayed*wet_mix with
// wet_mix limited to 1.0, rounded half up and saturated. The back end leaves
// a gap after each item it takes so that the feedback write of one item lands
// no later than the store read of the next (a write to the entry being read is
// forwarded), and waits for room in the output buffer. A sample passes the
// queue, the stage 1 and 2 registers and the output buffer. The store is a
// STORE_DEPTH x 16 memory with no clearing pass: entries the write pointer has
// not yet reached read as zero, so the block is ready right after reset. The
// user must write registers at byte addresses 0 (delay_samples), 4
// (feedback_gain) and 8 (wet_mix) only while the stream is idle; not enforced.
module feedback_delay_echo #(
	parameter int STORE_DEPTH = fde_pkg::STORE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample_in
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] sample_out
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import fde_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int QW = 16 + 2 * AW + 1;

	logic [DELAY_W-1:0] delay_q;
	logic [FBK_W-1:0]   fbk_q;
	logic [MIX_W-1:0]   mix_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	gain_t              gain;

	logic          q_push;
	logic [QW-1:0] q_wdata;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [QW-1:0] q_rdata;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			fbk_q   <= FBK_RESET;
			mix_q   <= MIX_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DELAY: delay_q <= pwdata[DELAY_W-1:0];
				REG_FBK:   fbk_q   <= pwdata[FBK_W-1:0];
				REG_MIX:   mix_q   <= pwdata[MIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Readback
	always_comb begin
		unique case (cfg_idx)
			REG_DELAY: prdata = 32'(delay_q);
			REG_FBK:   prdata = 32'(fbk_q);
			REG_MIX:   prdata = 32'(mix_q);
			default:   prdata = '0;
		endcase
	end

	assign gain.fbk = fbk_q;
	assign gain.mix = mix_q;

	fde_front #(
		.DEPTH(STORE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.delay    (delay_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	fde_queue #(
		.W(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_rdata)
	);

	fde_back #(
		.DEPTH(STORE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.gain     (gain),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
